@@ src/mlr_pkg.sv @@
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types and constants of the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

	localparam int unsigned COORD_BITS_DEF = 6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWAP,
		ST_ORDER,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic load;
		logic swap;
		logic order;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic out_free;
	} sts_t;

endpackage

@@ src/midpoint_line_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_top
// Rasterizes one line segment per input transaction with the midpoint method.
// ----------------------------------------------------------------------------
// The input channel carries one segment per transaction as two endpoints on
// a square tile. The output channel returns its pixels in walk order, one per
// transaction, with last_pixel set on the final one.
// A segment passes three setup steps before its first pixel: the endpoints
// are captured, coordinates of steep lines are swapped, and the ends are
// ordered and the decision value is set up. The walk then yields one pixel
// per cycle while the output register is empty or its pixel is being taken.
// The single walk counter and decision register hold one segment at a time;
// a new segment is taken once the last pixel of the previous one sits in
// the output register.
// Reset clears the controller to idle and empties the output register.
// When the receiver stalls, the output register holds its pixel and the
// walk pauses until that pixel is taken.
module midpoint_line_rasterizer_top #(
	parameter int unsigned COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  last_pixel
);
	import mlr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mlr_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (last_pixel)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a transaction");

	a_no_accept_mid_segment: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_pixel |-> !in_ready)
		else $error("input ready while a segment is still being walked");

	a_out_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(last_pixel))
		else $error("output transaction changed while the receiver stalled");
`endif

endmodule

@@ src/mlr_ctrl.sv @@
// ----------------------------------------------------------------------------
// mlr_ctrl
// Controller state machine: accepts a segment, sequences setup and the walk.
// ----------------------------------------------------------------------------
module mlr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mlr_pkg::sts_t sts,
	output mlr_pkg::cmd_t cmd
);
	import mlr_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_SWAP;
			end
			ST_SWAP:  state_next = ST_ORDER;
			ST_ORDER: state_next = ST_WALK;
			ST_WALK: begin
				if (sts.out_free && sts.last) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SWAP:  cmd.swap  = 1'b1;
			ST_ORDER: cmd.order = 1'b1;
			ST_WALK:  cmd.step  = sts.out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

@@ src/mlr_dp.sv @@
// ----------------------------------------------------------------------------
// mlr_dp
// Datapath: endpoint registers, setup arithmetic, walk registers and the
// output register.
// ----------------------------------------------------------------------------
module mlr_dp #(
	parameter int unsigned COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mlr_pkg::cmd_t         cmd,
	output mlr_pkg::sts_t         sts,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  last_pixel
);
	import mlr_pkg::*;

	localparam int unsigned N  = COORD_BITS;
	localparam int unsigned DW = COORD_BITS + 2;

	logic [N-1:0] x0_q, y0_q, x1_q, y1_q;
	logic         steep_q;
	logic         rising_q;
	logic [N-1:0] u_q, v_q, stop_q;
	logic signed [DW-1:0] d_q, aa_q, ab_q;
	logic         out_valid_q;
	logic [N-1:0] px_q, py_q;
	logic         last_q;

	logic [N-1:0] adx, ady;
	logic         steep;
	logic         swap_ends;
	logic [N-1:0] lx, ly, rx, ry;
	logic [N-1:0] ydiff, bw;
	logic         rising;
	logic signed [DW-1:0] aa, bs, half_b;
	logic         last;

	assign adx   = (x1_q >= x0_q) ? (x1_q - x0_q) : (x0_q - x1_q);
	assign ady   = (y1_q >= y0_q) ? (y1_q - y0_q) : (y0_q - y1_q);
	assign steep = adx < ady;

	assign swap_ends = x0_q > x1_q;
	assign lx = swap_ends ? x1_q : x0_q;
	assign ly = swap_ends ? y1_q : y0_q;
	assign rx = swap_ends ? x0_q : x1_q;
	assign ry = swap_ends ? y0_q : y1_q;
	assign rising = ly < ry;
	assign ydiff  = rising ? (ry - ly) : (ly - ry);
	assign bw     = rx - lx;
	assign aa     = -signed'({2'b00, ydiff});
	assign bs     = signed'({2'b00, bw});
	assign half_b = signed'({3'b000, bw[N-1:1]});

	assign last         = u_q == stop_q;
	assign sts.last     = last;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q <= x_start;
			y0_q <= y_start;
			x1_q <= x_end;
			y1_q <= y_end;
		end else if (cmd.swap) begin
			steep_q <= steep;
			if (steep) begin
				x0_q <= y0_q;
				y0_q <= x0_q;
				x1_q <= y1_q;
				y1_q <= x1_q;
			end
		end
		if (cmd.order) begin
			rising_q <= rising;
			u_q      <= rising ? lx : rx;
			v_q      <= rising ? ly : ry;
			stop_q   <= rising ? rx : lx;
			aa_q     <= aa;
			ab_q     <= aa + bs;
			d_q      <= aa + half_b;
		end else if (cmd.step) begin
			u_q <= rising_q ? (u_q + 1'b1) : (u_q - 1'b1);
			if (d_q < 0) begin
				v_q <= v_q + 1'b1;
				d_q <= d_q + ab_q;
			end else begin
				d_q <= d_q + aa_q;
			end
		end
		if (cmd.step) begin
			px_q   <= steep_q ? v_q : u_q;
			py_q   <= steep_q ? u_q : v_q;
			last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_x    = px_q;
	assign pixel_y    = py_q;
	assign last_pixel = last_q;

endmodule
